[design/gcbi_pkg.sv]
`default_nettype none

package gcbi_pkg;

    localparam int GRID_POINTS = 64;
    localparam int SATELLITES  = 64;

    localparam int SLOT_W     = $clog2(GRID_POINTS);
    localparam int SCAN_W     = $clog2(GRID_POINTS + 1);
    localparam int IONO_DEPTH = GRID_POINTS * SATELLITES;
    localparam int IONO_AW    = $clog2(IONO_DEPTH);

    localparam int MAC_A_W = 42;
    localparam int MAC_B_W = 18;

    // 180/pi * 2^24 split as HI * 2^15 + LO
    localparam logic signed [MAC_B_W-1:0] DEG_HI = 18'sd29335;
    localparam logic signed [MAC_B_W-1:0] DEG_LO = 18'sd14389;

    localparam logic [16:0] Q16_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_LOAD_POINT = 2'd0,
        OP_LOAD_IONO  = 2'd1,
        OP_QUERY      = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam logic [1:0] CFG_CELL_HEIGHT  = 2'd0;
    localparam logic [1:0] CFG_CELL_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_STEPS_ACROSS = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CONV,
        S_SCAN_TL,
        S_SCAN_NB,
        S_FRAC,
        S_DIV,
        S_READ,
        S_BLEND,
        S_OUT
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic clr;
        logic shl;
    } mac_ctl_t;

endpackage

`default_nettype wire

[design/gcbi_ram.sv]
`default_nettype none

module gcbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/gcbi_mac.sv]
`default_nettype none

module gcbi_mac import gcbi_pkg::*; (
    input  wire logic                      clk,
    input  wire logic signed [MAC_A_W-1:0] a,
    input  wire logic signed [MAC_B_W-1:0] b,
    input  wire mac_ctl_t                  ctl,
    output logic signed [MAC_A_W-1:0]      acc,
    output logic signed [31:0]             rnd
);

    logic signed [MAC_A_W+MAC_B_W-1:0] prod_reg;
    logic signed [63:0]                acc_reg;
    logic signed [63:0]                acc_next;
    logic signed [63:0]                addend;
    logic signed [63:0]                rounded;

    always_comb
    begin
        addend = ctl.shl ? (64'(prod_reg) <<< 15) : 64'(prod_reg);
        acc_next = acc_reg;
        if (ctl.acc_en)
        begin
            acc_next = (ctl.clr ? 64'sd0 : acc_reg) + addend;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    // floor((acc + 2^31) / 2^32)
    assign rounded = acc_reg + 64'sd2147483648;
    assign rnd     = rounded[63:32];
    assign acc     = acc_reg[MAC_A_W-1:0];

endmodule

`default_nettype wire

[design/gcbi_div.sv]
`default_nettype none

module gcbi_div import gcbi_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] num,
    input  wire logic [30:0] den,
    output logic             done,
    output logic [16:0]      quot
);

    // round(num*65536/den) for num < den: (num*2^17 + den) / (2*den)
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [31:0] rem_reg, rem_next;
    logic [16:0] lo_reg, lo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [16:0] q_reg, q_next;
    logic [47:0] big;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        big   = {num, 17'b0} + {17'b0, den};
        trial = {rem_reg, lo_reg[16]};
        diff  = trial - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            rem_next = {1'b0, big[47:17]};
            lo_next  = big[16:0];
            dvs_next = {den, 1'b0};
            cnt_next = 5'd17;
        end
        else if (cnt_reg != 5'd0)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                q_next   = {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[15:0], 1'b0};
            end
            lo_next  = {lo_reg[15:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

[design/grid_correction_bilinear_interp.sv]
// Load word: accepted whenever the block is idle.
// Query word: handled in up to two passes through the header RAM read port, up to two
// 17-step divisions and the shared multiply-accumulate (6 products per blended value).
// One word at a time; the next word is taken while the result waits in the output register.
// Reset: config and valid bits clear at once; the ionospheric table is then swept clear,
// entry by entry, with in_stall high.
`default_nettype none

module grid_correction_bilinear_interp import gcbi_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [25:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic [5:0]         slot,
    input  wire logic               present,
    input  wire logic [5:0]         grid_number,
    input  wire logic signed [27:0] point_latitude,
    input  wire logic signed [28:0] point_longitude,
    input  wire logic               tropo_present,
    input  wire logic signed [23:0] wet_or_iono_value,
    input  wire logic signed [23:0] dry_value,
    input  wire logic [5:0]         sat_id,
    input  wire logic signed [29:0] query_latitude,
    input  wire logic signed [30:0] query_longitude,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              iono_status,
    output logic signed [23:0]      iono_residual,
    output logic [1:0]              tropo_status,
    output logic signed [23:0]      wet_delay,
    output logic signed [23:0]      dry_delay
);

    state_t state_reg, state_next;

    logic [IONO_AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [25:0]            ch_reg, ch_next;
    logic [25:0]            cw_reg, cw_next;
    logic [5:0]             steps_reg, steps_next;
    logic [GRID_POINTS-1:0] hvalid_reg, hvalid_next;
    logic [GRID_POINTS-1:0] tpres_reg, tpres_next;
    logic [2:0]             step_reg, step_next;
    logic                   ph_reg, ph_next;
    logic [1:0]             qsel_reg, qsel_next;
    logic                   axis_reg, axis_next;
    logic [2:0]             rd_cnt_reg, rd_cnt_next;
    logic [SCAN_W-1:0]      scan_reg, scan_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [2:0]             fnd_reg, fnd_next;
    logic                   out_vld_reg, out_vld_next;

    logic [SLOT_W-1:0]        pipe_idx_reg, pipe_idx_next;
    logic [5:0]               sat_reg, sat_next;
    logic signed [29:0]       qlat_reg, qlat_next;
    logic signed [30:0]       qlon_reg, qlon_next;
    logic signed [29:0]       lat_reg, lat_next;
    logic signed [29:0]       lon_reg, lon_next;
    logic [5:0]               tl_grid_reg, tl_grid_next;
    logic signed [27:0]       tl_lat_reg, tl_lat_next;
    logic signed [28:0]       tl_lon_reg, tl_lon_next;
    logic signed [27:0]       br_lat_reg, br_lat_next;
    logic signed [28:0]       br_lon_reg, br_lon_next;
    logic [SLOT_W-1:0]        cidx_reg [4];
    logic [SLOT_W-1:0]        cidx_next [4];
    logic [16:0]              tx_reg, tx_next;
    logic [16:0]              ty_reg, ty_next;
    logic signed [23:0]       iono_c_reg [4];
    logic signed [23:0]       iono_c_next [4];
    logic signed [23:0]       wet_c_reg [4];
    logic signed [23:0]       wet_c_next [4];
    logic signed [23:0]       dry_c_reg [4];
    logic signed [23:0]       dry_c_next [4];
    logic [3:0]               ip_c_reg, ip_c_next;
    logic [3:0]               tp_c_reg, tp_c_next;
    logic signed [MAC_A_W-1:0] left_reg, left_next;
    logic signed [MAC_A_W-1:0] right_reg, right_next;
    logic [1:0]               ist_reg, ist_next;
    logic [1:0]               tst_reg, tst_next;
    logic signed [23:0]       ires_reg, ires_next;
    logic signed [23:0]       wres_reg, wres_next;
    logic signed [23:0]       dres_reg, dres_next;
    logic [1:0]               o_ist_reg, o_ist_next;
    logic [1:0]               o_tst_reg, o_tst_next;
    logic signed [23:0]       o_ires_reg, o_ires_next;
    logic signed [23:0]       o_wet_reg, o_wet_next;
    logic signed [23:0]       o_dry_reg, o_dry_next;

    logic        in_acc;
    op_t         op;
    logic        slot_ok;
    logic        sat_in_ok;
    logic        sat_q_ok;
    logic [SLOT_W-1:0] slot_idx;

    logic [62:0] hdr_rd;
    logic [62:0] hdr_wdata;
    logic        hdr_we;
    logic [47:0] tro_rd;
    logic [24:0] iono_rd;
    logic        iono_we;
    logic [IONO_AW-1:0] iono_waddr;
    logic [IONO_AW-1:0] iono_raddr;
    logic [24:0] iono_wdata;

    logic signed [27:0] hdr_lat;
    logic signed [28:0] hdr_lon;
    logic [5:0]         hdr_g;
    logic signed [31:0] lat32, lon32, lat_lo, lat_hi, lon_lo, lon_hi;
    logic               entry_ok;
    logic               tl_hit;
    logic               scan_done;
    logic [7:0]         tgt1, tgt2, tgt3, stride;

    logic signed [30:0] num, den;
    logic [30:0]        nabs, dabs;
    logic               frac_zero, frac_sat, div_start, div_done;
    logic [16:0]        div_q;

    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    mac_ctl_t                  mac_ctl;
    logic signed [MAC_A_W-1:0] mac_acc;
    logic signed [31:0]        mac_rnd;
    logic [1:0]                corner;
    logic signed [23:0]        cval;
    logic [1:0]                rd_k;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign op        = op_t'(opcode);
    assign slot_ok   = 32'(slot) < 32'(GRID_POINTS);
    assign sat_in_ok = 32'(sat_id) < 32'(SATELLITES);
    assign sat_q_ok  = 32'(sat_reg) < 32'(SATELLITES);
    assign slot_idx  = SLOT_W'(slot);

    // ---------------- storage ----------------
    assign hdr_we    = in_acc && (op == OP_LOAD_POINT) && slot_ok;
    assign hdr_wdata = {grid_number, point_latitude, point_longitude};

    gcbi_ram #(.WIDTH(63), .DEPTH(GRID_POINTS)) u_hdr (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (slot_idx),
        .wdata (hdr_wdata),
        .raddr (scan_reg[SLOT_W-1:0]),
        .rdata (hdr_rd)
    );

    gcbi_ram #(.WIDTH(48), .DEPTH(GRID_POINTS)) u_tro (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (slot_idx),
        .wdata ({wet_or_iono_value, dry_value}),
        .raddr (cidx_reg[rd_cnt_reg[1:0]]),
        .rdata (tro_rd)
    );

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            iono_we    = 1'b1;
            iono_waddr = clr_cnt_reg;
            iono_wdata = '0;
        end
        else
        begin
            iono_we    = in_acc && (op == OP_LOAD_IONO) && slot_ok && sat_in_ok;
            iono_waddr = IONO_AW'(slot_idx) * IONO_AW'(SATELLITES) + IONO_AW'(sat_id);
            iono_wdata = {present, wet_or_iono_value};
        end
    end

    assign iono_raddr = IONO_AW'(cidx_reg[rd_cnt_reg[1:0]]) * IONO_AW'(SATELLITES)
                      + IONO_AW'(sat_reg);

    gcbi_ram #(.WIDTH(25), .DEPTH(IONO_DEPTH)) u_iono (
        .clk   (clk),
        .we    (iono_we),
        .waddr (iono_waddr),
        .wdata (iono_wdata),
        .raddr (iono_raddr),
        .rdata (iono_rd)
    );

    // ---------------- scan compare ----------------
    assign hdr_g   = hdr_rd[62:57];
    assign hdr_lat = $signed(hdr_rd[56:29]);
    assign hdr_lon = $signed(hdr_rd[28:0]);
    assign lat32   = 32'(lat_reg);
    assign lon32   = 32'(lon_reg);
    assign lat_hi  = 32'(hdr_lat);
    assign lat_lo  = 32'(hdr_lat) - $signed({6'b0, ch_reg});
    assign lon_lo  = 32'(hdr_lon);
    assign lon_hi  = 32'(hdr_lon) + $signed({6'b0, cw_reg});

    assign entry_ok  = pipe_vld_reg && hvalid_reg[pipe_idx_reg];
    assign tl_hit    = entry_ok && (lat32 <= lat_hi) && (lat32 >= lat_lo)
                     && (lon32 >= lon_lo) && (lon32 <= lon_hi);
    assign scan_done = (scan_reg == SCAN_W'(GRID_POINTS)) && !pipe_vld_reg;

    // neighbour indexes, no wrap
    assign stride = {2'b0, steps_reg} + 8'd1;
    assign tgt1   = {2'b0, tl_grid_reg} + 8'd1;
    assign tgt2   = {2'b0, tl_grid_reg} + stride;
    assign tgt3   = tgt2 + 8'd1;

    // ---------------- fraction ----------------
    assign num  = axis_reg ? (31'(lon_reg) - 31'(tl_lon_reg)) : (31'(lat_reg) - 31'(tl_lat_reg));
    assign den  = axis_reg ? (31'(br_lon_reg) - 31'(tl_lon_reg))
                           : (31'(br_lat_reg) - 31'(tl_lat_reg));
    assign nabs = num[30] ? 31'(-num) : 31'(num);
    assign dabs = den[30] ? 31'(-den) : 31'(den);
    assign frac_zero = (den == 31'sd0) || (num == 31'sd0) || (num[30] != den[30]);
    assign frac_sat  = nabs >= dabs;
    assign div_start = (state_reg == S_FRAC) && !frac_zero && !frac_sat;

    gcbi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (nabs),
        .den   (dabs),
        .done  (div_done),
        .quot  (div_q)
    );

    // ---------------- shared multiply-accumulate ----------------
    always_comb
    begin
        case (step_reg)
            3'd0:    corner = 2'd0;
            3'd1:    corner = 2'd2;
            3'd2:    corner = 2'd1;
            3'd3:    corner = 2'd3;
            default: corner = 2'd0;
        endcase
        case (qsel_reg)
            2'd0:    cval = iono_c_reg[corner];
            2'd1:    cval = wet_c_reg[corner];
            default: cval = dry_c_reg[corner];
        endcase
    end

    always_comb
    begin
        mac_a   = '0;
        mac_b   = '0;
        mac_ctl = '0;
        if (state_reg == S_CONV)
        begin
            mac_a = (step_reg < 3'd3) ? MAC_A_W'(qlat_reg) : MAC_A_W'(qlon_reg);
            mac_b = (step_reg == 3'd0 || step_reg == 3'd3) ? DEG_HI : DEG_LO;
            mac_ctl.acc_en = ph_reg && (step_reg == 3'd0 || step_reg == 3'd1
                                        || step_reg == 3'd3 || step_reg == 3'd4);
            mac_ctl.clr = (step_reg == 3'd0 || step_reg == 3'd3);
            mac_ctl.shl = (step_reg == 3'd0 || step_reg == 3'd3);
        end
        else if (state_reg == S_BLEND)
        begin
            case (step_reg)
                3'd4:    mac_a = left_reg;
                3'd5:    mac_a = right_reg;
                default: mac_a = MAC_A_W'(cval);
            endcase
            case (step_reg)
                3'd0, 3'd2: mac_b = $signed({1'b0, Q16_ONE - tx_reg});
                3'd1, 3'd3: mac_b = $signed({1'b0, tx_reg});
                3'd4:       mac_b = $signed({1'b0, Q16_ONE - ty_reg});
                default:    mac_b = $signed({1'b0, ty_reg});
            endcase
            mac_ctl.acc_en = ph_reg && (step_reg < 3'd6);
            mac_ctl.clr    = (step_reg == 3'd0 || step_reg == 3'd2 || step_reg == 3'd4);
            mac_ctl.shl    = 1'b0;
        end
    end

    gcbi_mac u_mac (
        .clk (clk),
        .a   (mac_a),
        .b   (mac_b),
        .ctl (mac_ctl),
        .acc (mac_acc),
        .rnd (mac_rnd)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == IONO_AW'(IONO_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && op == OP_QUERY)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (step_reg == 3'd5)
                begin
                    state_next = S_SCAN_TL;
                end
            end
            S_SCAN_TL:
            begin
                if (tl_hit)
                begin
                    state_next = S_SCAN_NB;
                end
                else if (scan_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN_NB:
            begin
                if (scan_done)
                begin
                    state_next = (&fnd_reg) ? S_FRAC : S_OUT;
                end
            end
            S_FRAC:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = axis_reg ? S_READ : S_FRAC;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = axis_reg ? S_READ : S_FRAC;
                end
            end
            S_READ:
            begin
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                if (step_reg == 3'd6 && qsel_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        ch_next       = ch_reg;
        cw_next       = cw_reg;
        steps_next    = steps_reg;
        hvalid_next   = hvalid_reg;
        tpres_next    = tpres_reg;
        step_next     = step_reg;
        ph_next       = ph_reg;
        qsel_next     = qsel_reg;
        axis_next     = axis_reg;
        rd_cnt_next   = rd_cnt_reg;
        scan_next     = scan_reg;
        pipe_vld_next = pipe_vld_reg;
        pipe_idx_next = pipe_idx_reg;
        fnd_next      = fnd_reg;
        out_vld_next  = out_vld_reg;
        sat_next      = sat_reg;
        qlat_next     = qlat_reg;
        qlon_next     = qlon_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        tl_grid_next  = tl_grid_reg;
        tl_lat_next   = tl_lat_reg;
        tl_lon_next   = tl_lon_reg;
        br_lat_next   = br_lat_reg;
        br_lon_next   = br_lon_reg;
        cidx_next     = cidx_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        iono_c_next   = iono_c_reg;
        wet_c_next    = wet_c_reg;
        dry_c_next    = dry_c_reg;
        ip_c_next     = ip_c_reg;
        tp_c_next     = tp_c_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        ist_next      = ist_reg;
        tst_next      = tst_reg;
        ires_next     = ires_reg;
        wres_next     = wres_reg;
        dres_next     = dres_reg;
        o_ist_next    = o_ist_reg;
        o_tst_next    = o_tst_reg;
        o_ires_next   = o_ires_reg;
        o_wet_next    = o_wet_reg;
        o_dry_next    = o_dry_reg;
        rd_k          = rd_cnt_reg[1:0] - 2'd1;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CELL_HEIGHT:  ch_next    = cfg_data;
                CFG_CELL_WIDTH:   cw_next    = cfg_data;
                CFG_STEPS_ACROSS: steps_next = cfg_data[5:0];
                default:          ch_next    = ch_reg;
            endcase
        end

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        if (hdr_we)
        begin
            hvalid_next[slot_idx] = present;
            tpres_next[slot_idx]  = tropo_present;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + IONO_AW'(1);
            end
            S_IDLE:
            begin
                sat_next      = sat_id;
                qlat_next     = query_latitude;
                qlon_next     = query_longitude;
                step_next     = 3'd0;
                ph_next       = 1'b0;
                scan_next     = '0;
                pipe_vld_next = 1'b0;
                fnd_next      = 3'b0;
                axis_next     = 1'b0;
                rd_cnt_next   = 3'd0;
                qsel_next     = 2'd0;
                ist_next      = ST_OUTSIDE;
                tst_next      = ST_OUTSIDE;
                ires_next     = '0;
                wres_next     = '0;
                dres_next     = '0;
            end
            S_CONV:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    step_next = step_reg + 3'd1;
                end
                if (step_reg == 3'd2 && !ph_reg)
                begin
                    lat_next = mac_rnd[29:0];
                end
                if (step_reg == 3'd5)
                begin
                    lon_next = mac_rnd[29:0];
                end
            end
            S_SCAN_TL, S_SCAN_NB:
            begin
                pipe_vld_next = scan_reg < SCAN_W'(GRID_POINTS);
                pipe_idx_next = scan_reg[SLOT_W-1:0];
                if (scan_reg < SCAN_W'(GRID_POINTS))
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
                if (state_reg == S_SCAN_TL)
                begin
                    if (tl_hit)
                    begin
                        tl_grid_next  = hdr_g;
                        tl_lat_next   = hdr_lat;
                        tl_lon_next   = hdr_lon;
                        cidx_next[0]  = pipe_idx_reg;
                        scan_next     = '0;
                        pipe_vld_next = 1'b0;
                    end
                end
                else if (entry_ok)
                begin
                    if (!fnd_reg[0] && {2'b0, hdr_g} == tgt1)
                    begin
                        fnd_next[0]  = 1'b1;
                        cidx_next[1] = pipe_idx_reg;
                    end
                    if (!fnd_reg[1] && {2'b0, hdr_g} == tgt2)
                    begin
                        fnd_next[1]  = 1'b1;
                        cidx_next[2] = pipe_idx_reg;
                    end
                    if (!fnd_reg[2] && {2'b0, hdr_g} == tgt3)
                    begin
                        fnd_next[2]  = 1'b1;
                        cidx_next[3] = pipe_idx_reg;
                        br_lat_next  = hdr_lat;
                        br_lon_next  = hdr_lon;
                    end
                end
            end
            S_FRAC:
            begin
                if (!div_start)
                begin
                    if (axis_reg)
                    begin
                        ty_next = frac_zero ? 17'd0 : Q16_ONE;
                    end
                    else
                    begin
                        tx_next = frac_zero ? 17'd0 : Q16_ONE;
                    end
                    axis_next = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                    begin
                        ty_next = div_q;
                    end
                    else
                    begin
                        tx_next = div_q;
                    end
                    axis_next = 1'b1;
                end
            end
            S_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg != 3'd0)
                begin
                    iono_c_next[rd_k] = $signed(iono_rd[23:0]);
                    ip_c_next[rd_k]   = iono_rd[24];
                    wet_c_next[rd_k]  = $signed(tro_rd[47:24]);
                    dry_c_next[rd_k]  = $signed(tro_rd[23:0]);
                    tp_c_next[rd_k]   = tpres_reg[cidx_reg[rd_k]];
                end
                step_next = 3'd0;
                ph_next   = 1'b0;
                qsel_next = 2'd0;
            end
            S_BLEND:
            begin
                if (step_reg == 3'd2 && !ph_reg)
                begin
                    left_next = mac_acc;
                end
                if (step_reg == 3'd4 && !ph_reg)
                begin
                    right_next = mac_acc;
                end
                if (step_reg == 3'd6)
                begin
                    case (qsel_reg)
                        2'd0:    ires_next = mac_rnd[23:0];
                        2'd1:    wres_next = mac_rnd[23:0];
                        default: dres_next = mac_rnd[23:0];
                    endcase
                    step_next = 3'd0;
                    ph_next   = 1'b0;
                    qsel_next = qsel_reg + 2'd1;
                    if (qsel_reg == 2'd2)
                    begin
                        ist_next = (sat_q_ok && (&ip_c_reg)) ? ST_OK : ST_MISSING;
                        tst_next = (&tp_c_reg) ? ST_OK : ST_MISSING;
                    end
                end
                else
                begin
                    ph_next = !ph_reg;
                    if (ph_reg)
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    out_vld_next = 1'b1;
                    o_ist_next   = ist_reg;
                    o_tst_next   = tst_reg;
                    o_ires_next  = (ist_reg == ST_OK) ? ires_reg : 24'sd0;
                    o_wet_next   = (tst_reg == ST_OK) ? wres_reg : 24'sd0;
                    o_dry_next   = (tst_reg == ST_OK) ? dres_reg : 24'sd0;
                end
            end
            default: clr_cnt_next = clr_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            ch_reg       <= '0;
            cw_reg       <= '0;
            steps_reg    <= '0;
            hvalid_reg   <= '0;
            tpres_reg    <= '0;
            step_reg     <= '0;
            ph_reg       <= 1'b0;
            qsel_reg     <= '0;
            axis_reg     <= 1'b0;
            rd_cnt_reg   <= '0;
            scan_reg     <= '0;
            pipe_vld_reg <= 1'b0;
            fnd_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            ch_reg       <= ch_next;
            cw_reg       <= cw_next;
            steps_reg    <= steps_next;
            hvalid_reg   <= hvalid_next;
            tpres_reg    <= tpres_next;
            step_reg     <= step_next;
            ph_reg       <= ph_next;
            qsel_reg     <= qsel_next;
            axis_reg     <= axis_next;
            rd_cnt_reg   <= rd_cnt_next;
            scan_reg     <= scan_next;
            pipe_vld_reg <= pipe_vld_next;
            fnd_reg      <= fnd_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= pipe_idx_next;
        sat_reg      <= sat_next;
        qlat_reg     <= qlat_next;
        qlon_reg     <= qlon_next;
        lat_reg      <= lat_next;
        lon_reg      <= lon_next;
        tl_grid_reg  <= tl_grid_next;
        tl_lat_reg   <= tl_lat_next;
        tl_lon_reg   <= tl_lon_next;
        br_lat_reg   <= br_lat_next;
        br_lon_reg   <= br_lon_next;
        cidx_reg     <= cidx_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        iono_c_reg   <= iono_c_next;
        wet_c_reg    <= wet_c_next;
        dry_c_reg    <= dry_c_next;
        ip_c_reg     <= ip_c_next;
        tp_c_reg     <= tp_c_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        ist_reg      <= ist_next;
        tst_reg      <= tst_next;
        ires_reg     <= ires_next;
        wres_reg     <= wres_next;
        dres_reg     <= dres_next;
        o_ist_reg    <= o_ist_next;
        o_tst_reg    <= o_tst_next;
        o_ires_reg   <= o_ires_next;
        o_wet_reg    <= o_wet_next;
        o_dry_reg    <= o_dry_next;
    end

    assign out_valid     = out_vld_reg;
    assign iono_status   = o_ist_reg;
    assign iono_residual = o_ires_reg;
    assign tropo_status  = o_tst_reg;
    assign wet_delay     = o_wet_reg;
    assign dry_delay     = o_dry_reg;

    // no result can exist before the first query after the clear sweep
    a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_vld_reg)
        else $error("result word during table clear");

    // a query word makes the block busy on the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == OP_QUERY) |=> in_stall)
        else $error("query accepted without going busy");

    // residual is zeroed whenever its status is not success
    a_iono_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && iono_status != ST_OK) |-> iono_residual == 24'sd0)
        else $error("nonzero residual with failure status");

    a_tropo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tropo_status != ST_OK) |-> (wet_delay == 24'sd0 && dry_delay == 24'sd0))
        else $error("nonzero delay with failure status");

endmodule

`default_nettype wire

[verif/grid_correction_bilinear_interp_tb.sv]
`timescale 1ns / 100ps

module grid_correction_bilinear_interp_tb;
    import gcbi_pkg::*;

    localparam longint DEG = 64'sd1048576;          // one degree in 2^-20 units
    localparam longint CELL_MAX = 64'sd52428800;
    localparam longint QLAT_MAX = 64'sd421657428;
    localparam longint QLON_MAX = 64'sd843314857;
    localparam longint PLAT_MAX = 64'sd94371840;
    localparam longint PLON_MAX = 64'sd188743680;
    localparam int     WORD_TARGET = 1550;
    localparam int     SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  ist;
        logic [23:0] ires;
        logic [1:0]  tst;
        logic [23:0] wet;
        logic [23:0] dry;
    } corr_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [25:0]         cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          opcode;
    logic [5:0]          slot;
    logic                present;
    logic [5:0]          grid_number;
    logic signed [27:0]  point_latitude;
    logic signed [28:0]  point_longitude;
    logic                tropo_present;
    logic signed [23:0]  wet_or_iono_value;
    logic signed [23:0]  dry_value;
    logic [5:0]          sat_id;
    logic signed [29:0]  query_latitude;
    logic signed [30:0]  query_longitude;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          iono_status;
    logic signed [23:0]  iono_residual;
    logic [1:0]          tropo_status;
    logic signed [23:0]  wet_delay;
    logic signed [23:0]  dry_delay;

    grid_correction_bilinear_interp u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .slot              (slot),
        .present           (present),
        .grid_number       (grid_number),
        .point_latitude    (point_latitude),
        .point_longitude   (point_longitude),
        .tropo_present     (tropo_present),
        .wet_or_iono_value (wet_or_iono_value),
        .dry_value         (dry_value),
        .sat_id            (sat_id),
        .query_latitude    (query_latitude),
        .query_longitude   (query_longitude),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .iono_status       (iono_status),
        .iono_residual     (iono_residual),
        .tropo_status      (tropo_status),
        .wet_delay         (wet_delay),
        .dry_delay         (dry_delay)
    );

    // shadow copy of the grid table and registers
    logic        grid_valid [GRID_POINTS];
    int          grid_index [GRID_POINTS];
    longint      grid_lat   [GRID_POINTS];
    longint      grid_lon   [GRID_POINTS];
    logic        tropo_ok   [GRID_POINTS];
    longint      tropo_wet  [GRID_POINTS];
    longint      tropo_dry  [GRID_POINTS];
    logic        iono_ok    [GRID_POINTS][SATELLITES];
    longint      iono_val   [GRID_POINTS][SATELLITES];
    longint      step_lat;
    longint      step_lon;
    int          row_steps;

    corr_t       pending_corr[$];
    int          mismatches;
    int          words_sent;
    int          queries_checked;
    int          phases_run;
    bit          quiet;
    bit          hold_req;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint rand_span(longint m);
        return longint'($urandom_range(0, 32'(2 * m))) - m;
    endfunction

    function automatic longint rand_value();
        return longint'($urandom_range(0, 16777215)) - 64'sd8388608;
    endfunction

    function automatic longint to_deg(longint q);
        return (q * 64'sd961263669 + (64'sd1 <<< 31)) >>> 32;
    endfunction

    // inverse of to_deg, close enough to land inside a chosen cell
    function automatic longint to_rad(longint du, longint lim);
        longint q;
        q = longint'($rtoi(real'(du) * 256.0 * 3.141592653589793 / 180.0));
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    function automatic longint q16_fraction(longint num, longint den);
        longint n;
        longint d;
        longint t;
        if (den == 0 || num == 0)
            return 0;
        if ((num < 0) != (den < 0))
            return 0;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        t = (n * 131072 + d) / (2 * d);
        return (t > 65536) ? 65536 : t;
    endfunction

    function automatic longint bilinear(longint a, longint b, longint c, longint d,
                                        longint tx, longint ty);
        longint left;
        longint right;
        left  = a * (65536 - tx) + c * tx;
        right = b * (65536 - tx) + d * tx;
        return (left * (65536 - ty) + right * ty + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function automatic int find_point(int idx);
        for (int i = 0; i < GRID_POINTS; i++)
            if (grid_valid[i] && grid_index[i] == idx)
                return i;
        return -1;
    endfunction

    function automatic corr_t predict_correction(logic [5:0] sat, longint qlat, longint qlon);
        longint lat;
        longint lon;
        longint tx;
        longint ty;
        longint v;
        int     tl;
        int     tr;
        int     bl;
        int     br;
        corr_t  c;
        c.ist = ST_OUTSIDE;
        c.ires = '0;
        c.tst = ST_OUTSIDE;
        c.wet = '0;
        c.dry = '0;
        lat = to_deg(qlat);
        lon = to_deg(qlon);
        tl = -1;
        for (int i = 0; i < GRID_POINTS && tl < 0; i++)
            if (grid_valid[i] && lat <= grid_lat[i] && lat >= grid_lat[i] - step_lat &&
                lon >= grid_lon[i] && lon <= grid_lon[i] + step_lon)
                tl = i;
        if (tl < 0)
            return c;
        tr = find_point(grid_index[tl] + 1);
        bl = find_point(grid_index[tl] + row_steps + 1);
        br = find_point(grid_index[tl] + row_steps + 2);
        if (tr < 0 || bl < 0 || br < 0)
            return c;
        tx = q16_fraction(lat - grid_lat[tl], grid_lat[br] - grid_lat[tl]);
        ty = q16_fraction(lon - grid_lon[tl], grid_lon[br] - grid_lon[tl]);
        if (iono_ok[tl][sat] && iono_ok[tr][sat] && iono_ok[bl][sat] && iono_ok[br][sat])
        begin
            c.ist = ST_OK;
            v = bilinear(iono_val[tl][sat], iono_val[tr][sat], iono_val[bl][sat],
                         iono_val[br][sat], tx, ty);
            c.ires = v[23:0];
        end
        else
            c.ist = ST_MISSING;
        if (tropo_ok[tl] && tropo_ok[tr] && tropo_ok[bl] && tropo_ok[br])
        begin
            c.tst = ST_OK;
            v = bilinear(tropo_wet[tl], tropo_wet[tr], tropo_wet[bl], tropo_wet[br], tx, ty);
            c.wet = v[23:0];
            v = bilinear(tropo_dry[tl], tropo_dry[tr], tropo_dry[bl], tropo_dry[br], tx, ty);
            c.dry = v[23:0];
        end
        else
            c.tst = ST_MISSING;
        return c;
    endfunction

    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // drive one word, wait for acceptance, update the shadow state
    task automatic send_word(input op_t op, input logic [5:0] sl, input logic pr,
                             input logic [5:0] gn, input longint plat, input longint plon,
                             input logic tp, input longint wv, input longint dv,
                             input logic [5:0] sat, input longint qlat, input longint qlon);
        int n;
        opcode            <= op;
        slot              <= sl;
        present           <= pr;
        grid_number       <= gn;
        point_latitude    <= plat[27:0];
        point_longitude   <= plon[28:0];
        tropo_present     <= tp;
        wet_or_iono_value <= wv[23:0];
        dry_value         <= dv[23:0];
        sat_id            <= sat;
        query_latitude    <= qlat[29:0];
        query_longitude   <= qlon[30:0];
        in_valid          <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        case (op)
            OP_LOAD_POINT:
            begin
                grid_valid[sl] = pr;
                grid_index[sl] = gn;
                grid_lat[sl]   = plat;
                grid_lon[sl]   = plon;
                tropo_ok[sl]   = tp;
                tropo_wet[sl]  = wv;
                tropo_dry[sl]  = dv;
                words_sent++;
            end
            OP_LOAD_IONO:
            begin
                iono_ok[sl][sat]  = pr;
                iono_val[sl][sat] = wv;
                words_sent++;
            end
            OP_QUERY:
            begin
                pending_corr.push_back(predict_correction(sat, qlat, qlon));
                words_sent++;
            end
            default: ;
        endcase
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic load_point(input int sl, input logic ok, input int gn, input longint lat,
                              input longint lon, input logic tp, input longint wet,
                              input longint dry);
        send_word(OP_LOAD_POINT, sl, ok, gn, lat, lon, tp, wet, dry, $urandom,
                  rand_span(QLAT_MAX), rand_span(QLON_MAX));
    endtask

    task automatic load_iono(input int sl, input int sat, input logic ok, input longint val);
        send_word(OP_LOAD_IONO, sl, ok, $urandom, rand_span(PLAT_MAX), rand_span(PLON_MAX),
                  $urandom, val, rand_value(), sat, rand_span(QLAT_MAX), rand_span(QLON_MAX));
    endtask

    task automatic query_at(input int sat, input longint qlat, input longint qlon);
        send_word(OP_QUERY, $urandom, $urandom, $urandom, rand_span(PLAT_MAX),
                  rand_span(PLON_MAX), $urandom, rand_value(), rand_value(), sat, qlat, qlon);
    endtask

    task automatic query_deg(input int sat, input longint lat, input longint lon);
        query_at(sat, to_rad(lat, QLAT_MAX), to_rad(lon, QLON_MAX));
    endtask

    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_corr.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input longint val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[25:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CELL_HEIGHT:  step_lat = val[25:0];
            CFG_CELL_WIDTH:   step_lon = val[25:0];
            CFG_STEPS_ACROSS: row_steps = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input longint h, input longint w, input int steps);
        write_reg(CFG_CELL_HEIGHT, h);
        write_reg(CFG_CELL_WIDTH, w);
        write_reg(CFG_STEPS_ACROSS, steps);
    endtask

    // receiver: short random stalls, occasional long ones, forced hold on request
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                burst = 800;
            end
            if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                burst = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        corr_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_corr.size() == 0)
            begin
                $error("unexpected result word");
                mismatches++;
            end
            else
            begin
                e = pending_corr.pop_front();
                queries_checked++;
                if (iono_status !== e.ist)
                begin
                    $error("iono_status exp %0d got %0d", e.ist, iono_status);
                    mismatches++;
                end
                if (iono_residual !== e.ires)
                begin
                    $error("iono_residual exp %0d got %0d", $signed(e.ires), iono_residual);
                    mismatches++;
                end
                if (tropo_status !== e.tst)
                begin
                    $error("tropo_status exp %0d got %0d", e.tst, tropo_status);
                    mismatches++;
                end
                if (wet_delay !== e.wet)
                begin
                    $error("wet_delay exp %0d got %0d", $signed(e.wet), wet_delay);
                    mismatches++;
                end
                if (dry_delay !== e.dry)
                begin
                    $error("dry_delay exp %0d got %0d", $signed(e.dry), dry_delay);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_registers();
        set_grid(CELL_MAX, CELL_MAX, 63);
        query_deg(0, 0, 0);
        set_grid(0, 0, 0);
        query_at(0, QLAT_MAX, QLON_MAX);
        query_at(63, -QLAT_MAX, -QLON_MAX);
    endtask

    // 2x2 cell at 10N 20E, one degree square
    task automatic test_directed();
        set_grid(DEG, DEG, 1);
        load_point(0, 1, 0, 10 * DEG, 20 * DEG, 1, -64'sd8388608, 64'sd8388607);
        load_point(1, 1, 1, 10 * DEG, 21 * DEG, 1, 64'sd8388607, -64'sd8388608);
        load_point(2, 1, 2, 9 * DEG, 20 * DEG, 1, 64'sd8388607, 64'sd8388607);
        load_point(3, 1, 3, 9 * DEG, 21 * DEG, 1, -64'sd8388608, 0);
        for (int i = 0; i < 4; i++)
            load_iono(i, 5, 1, (i % 2) ? 64'sd8388607 : -64'sd8388608);
        query_deg(5, 9 * DEG + DEG / 2, 20 * DEG + DEG / 2);
        query_deg(6, 9 * DEG + DEG / 3, 20 * DEG + DEG / 4);     // no residual for sat 6
        query_deg(5, 0, 0);                                      // outside every cell
        send_word(OP_NONE, 0, 1, 0, 0, 0, 1, 0, 0, 5, 0, 0);     // unused opcode: no result
        // reload without tropo; residuals must survive the reload
        load_point(3, 1, 3, 9 * DEG, 21 * DEG, 0, 0, 0);
        query_deg(5, 10 * DEG - 1, 20 * DEG + 1);
        // lower-right corner above the top-left one: opposite signs give zero fraction
        load_point(3, 1, 3, 11 * DEG, 21 * DEG, 1, 100, -100);
        query_deg(5, 9 * DEG + DEG / 5, 20 * DEG + DEG / 7);
        // zero latitude span
        load_point(3, 1, 3, 10 * DEG, 21 * DEG, 1, 7, 9);
        query_deg(5, 9 * DEG + DEG / 2, 20 * DEG + DEG / 2);
        // index 63 has no right neighbour inside the index range
        load_point(4, 1, 63, 50 * DEG, 50 * DEG, 1, 1, 1);
        query_deg(5, 50 * DEG - DEG / 2, 50 * DEG + DEG / 2);
    endtask

    // output held off while the sender keeps offering queries
    task automatic test_backpressure();
        wait_idle();
        quiet = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            query_deg(5, 9 * DEG + DEG / 2 + i * 1000, 20 * DEG + DEG / 2);
        quiet = 1'b0;
    endtask

    task automatic random_phase(input int ph);
        int     steps;
        int     stride;
        int     rows;
        int     npts;
        int     order [GRID_POINTS];
        int     sats [3];
        int     r;
        int     c;
        int     k;
        longint h;
        longint w;
        longint lat0;
        longint lon0;
        k = $urandom_range(0, 7);
        steps = (k == 0) ? 63 : (k == 1) ? 0 : $urandom_range(1, 6);
        stride = steps + 1;
        rows = (GRID_POINTS / stride < 6) ? GRID_POINTS / stride : 6;
        npts = rows * stride;
        h = 163577856 / rows;
        if (h > CELL_MAX)
            h = CELL_MAX;
        w = 356515840 / stride;
        if (w > CELL_MAX)
            w = CELL_MAX;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            h = 0;
            w = 0;
        end
        else if (k > 2)
        begin
            h = $urandom_range(1, 32'(h));
            w = $urandom_range(1, 32'(w));
        end
        set_grid(h, w, steps);
        quiet = (ph == 2);
        lat0 = 81788928;
        lon0 = -178257920;
        for (int i = 0; i < GRID_POINTS; i++)
            order[i] = i;
        order.shuffle();
        for (int i = 0; i < GRID_POINTS; i++)
            if (i < npts)
                load_point(order[i], $urandom_range(0, 15) != 0, i,
                           lat0 - (i / stride) * h, lon0 + (i % stride) * w,
                           $urandom_range(0, 11) != 0, rand_value(), rand_value());
            else
                load_point(order[i], $urandom_range(0, 7) == 0, $urandom,
                           rand_span(PLAT_MAX), rand_span(PLON_MAX), $urandom,
                           rand_value(), rand_value());
        for (int s = 0; s < 3; s++)
        begin
            sats[s] = $urandom_range(0, 63);
            for (int i = 0; i < npts; i++)
                load_iono(order[i], sats[s], $urandom_range(0, 9) != 0, rand_value());
        end
        for (int q = 0; q < 45; q++)
        begin
            k = $urandom_range(0, 19);
            if (k < 2)
                load_iono($urandom, $urandom, $urandom, rand_value());
            else if (k == 2)
                load_point($urandom, 1, $urandom, rand_span(PLAT_MAX), rand_span(PLON_MAX),
                           $urandom, rand_value(), rand_value());
            else if (k < 16)
            begin
                r = $urandom_range(0, rows - 1);
                c = $urandom_range(0, stride - 1);
                query_deg(($urandom_range(0, 4) != 0) ? sats[$urandom_range(0, 2)] : $urandom,
                          lat0 - r * h - (h * $urandom_range(0, 1024)) / 1024,
                          lon0 + c * w + (w * $urandom_range(0, 1024)) / 1024);
            end
            else
                query_at($urandom, rand_span(QLAT_MAX), rand_span(QLON_MAX));
        end
        quiet = 1'b0;
        phases_run++;
    endtask

    task automatic test_random();
        int ph;
        ph = 0;
        while (words_sent < WORD_TARGET)
        begin
            random_phase(ph);
            ph++;
        end
    endtask

    initial
    begin
        mismatches = 0;
        words_sent = 0;
        queries_checked = 0;
        phases_run = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        step_lat = 0;
        step_lon = 0;
        row_steps = 0;
        for (int i = 0; i < GRID_POINTS; i++)
        begin
            grid_valid[i] = 1'b0;
            grid_index[i] = 0;
            grid_lat[i] = 0;
            grid_lon[i] = 0;
            tropo_ok[i] = 1'b0;
            tropo_wet[i] = 0;
            tropo_dry[i] = 0;
            for (int s = 0; s < SATELLITES; s++)
            begin
                iono_ok[i][s] = 1'b0;
                iono_val[i][s] = 0;
            end
        end
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_CELL_HEIGHT;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        out_stall         <= 1'b0;
        opcode            <= OP_NONE;
        slot              <= '0;
        present           <= 1'b0;
        grid_number       <= '0;
        point_latitude    <= '0;
        point_longitude   <= '0;
        tropo_present     <= 1'b0;
        wet_or_iono_value <= '0;
        dry_value         <= '0;
        sat_id            <= '0;
        query_latitude    <= '0;
        query_longitude   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_registers();
        test_directed();
        test_backpressure();
        test_random();

        wait_idle();
        $display("%0d words sent, %0d query results checked over %0d random grid phases",
                 words_sent, queries_checked, phases_run);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
